@@ src/arcnet_tx_page_formatter_defines.svh @@
// Assertion macros shared by the checker of the ARCNET transmit page formatter.
// No dependencies; include by bare file name.
`ifndef ARCNET_TX_PAGE_FORMATTER_DEFINES_SVH
`define ARCNET_TX_PAGE_FORMATTER_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define ATF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a stalled valid stays high with its payload held.
`define ATF_ASSERT_HOLD(label, clk, rst_n, vld, rdy, pay, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> (vld && $stable(pay))) else $error(msg);

`endif

@@ src/atf_pkg.sv @@
// Package of the ARCNET transmit page formatter: constants, codes and word types.
// No dependencies; imported by every module of the block.
package atf_pkg;

  localparam int MAX_PAYLOAD = 508;
  localparam int SHORT_LIMIT = 253;
  localparam int PAGE_BYTES  = 512;
  localparam int HALF_PAGE   = 256;

  // Low bits of the transmit-enable command.
  localparam logic [2:0] CMD_TX_LOW = 3'b011;

  // Job queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_CMD    = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    JOB_REJECT    = 3'd0,
    JOB_SHORT     = 3'd1,
    JOB_LONG      = 3'd2,
    JOB_BYTE      = 3'd3,
    JOB_BYTE_LAST = 3'd4
  } job_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] dest_address;
    logic [8:0] packet_length;
    logic [7:0] payload_byte;
  } in_t;

  typedef struct packed {
    kind_e       result_kind;
    logic [10:0] mem_address;
    logic [7:0]  mem_data;
    logic [7:0]  command_byte;
    logic        last;
  } out_t;

  // One classified item, as queued for the back end.
  typedef struct packed {
    job_e        cls;
    logic [1:0]  page;
    logic [7:0]  src;
    logic [7:0]  dest;
    logic [7:0]  cnt;
    logic [10:0] addr;
    logic [7:0]  data;
  } job_t;

endpackage

@@ src/atf_queue.sv @@
// Short job queue between the front and back ends of the formatter.
// Depends on atf_pkg for job_t and the queue depth.
module atf_queue import atf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output job_t head_o
);

  job_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o       = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? Q_PTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = do_pop ? Q_PTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = Q_CNT_W'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = Q_CNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

@@ src/atf_front.sv @@
// Front end of the formatter: accepts items, holds the packet state, classifies jobs.
// Depends on atf_pkg for the word types and length limits.
module atf_front import atf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  input  logic       cfg_valid_i,
  input  logic [7:0] cfg_data_i,
  input  logic       q_full_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [7:0]  node_addr_q;
  logic        page_sel_q, page_sel_d;
  logic        active_q, active_d;
  logic [8:0]  left_q, left_d;
  logic [10:0] wptr_q, wptr_d;

  logic [1:0]  page;
  logic [8:0]  len;
  logic        bad_len, long_fmt, accept;
  logic [9:0]  offset;
  logic [8:0]  left_dec;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  // Transmit page alternates between 2 and 3.
  assign page     = {1'b1, page_sel_q};
  assign len      = in_data_i.packet_length;
  assign bad_len  = (len == '0) || (len > 9'(MAX_PAYLOAD));
  assign long_fmt = (len > 9'(SHORT_LIMIT));
  assign offset   = long_fmt ? (10'(PAGE_BYTES) - {1'b0, len})
                             : (10'(HALF_PAGE) - {1'b0, len});
  assign left_dec = left_q - 9'd1;

  always_comb begin
    page_sel_d = page_sel_q;
    active_d   = active_q;
    left_d     = left_q;
    wptr_d     = wptr_q;

    job_o.cls  = JOB_REJECT;
    job_o.page = page;
    job_o.src  = node_addr_q;
    job_o.dest = in_data_i.dest_address;
    job_o.cnt  = offset[7:0];
    job_o.addr = wptr_q;
    job_o.data = in_data_i.payload_byte;

    if (!in_data_i.operation) begin
      if (!bad_len) begin
        job_o.cls = long_fmt ? JOB_LONG : JOB_SHORT;
        if (accept) begin
          active_d = 1'b1;
          left_d   = len;
          wptr_d   = {page, 9'd0} + 11'(offset);
        end
      end
    end else if (active_q) begin
      job_o.cls = (left_dec == '0) ? JOB_BYTE_LAST : JOB_BYTE;
      if (accept) begin
        left_d = left_dec;
        wptr_d = wptr_q + 11'd1;
        if (left_dec == '0) begin
          active_d   = 1'b0;
          page_sel_d = !page_sel_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_addr_q <= '0;
      page_sel_q  <= 1'b0;
      active_q    <= 1'b0;
      left_q      <= '0;
      wptr_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        node_addr_q <= cfg_data_i;
      end
      page_sel_q <= page_sel_d;
      active_q   <= active_d;
      left_q     <= left_d;
      wptr_q     <= wptr_d;
    end
  end

endmodule

@@ src/atf_back.sv @@
// Back end of the formatter: expands queued jobs into result words, one per cycle unless the output stalls.
// Depends on atf_pkg for job_t, out_t and the result codes.
module atf_back import atf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic head_valid_i,
  input  job_t head_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic [1:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  out_t       out_q, res;
  logic       fin, load;

  always_comb begin
    res              = '0;
    res.result_kind  = KIND_WRITE;
    fin              = 1'b1;
    unique case (head_i.cls)
      JOB_SHORT: begin
        res.mem_address = {head_i.page, 7'd0, step_q};
        unique case (step_q)
          2'd0:    res.mem_data = head_i.src;
          2'd1:    res.mem_data = head_i.dest;
          default: res.mem_data = head_i.cnt;
        endcase
        fin = (step_q == 2'd2);
      end
      JOB_LONG: begin
        res.mem_address = {head_i.page, 7'd0, step_q};
        unique case (step_q)
          2'd0:    res.mem_data = head_i.src;
          2'd1:    res.mem_data = head_i.dest;
          2'd2:    res.mem_data = 8'd0;
          default: res.mem_data = head_i.cnt;
        endcase
        fin = (step_q == 2'd3);
      end
      JOB_BYTE: begin
        res.mem_address = head_i.addr;
        res.mem_data    = head_i.data;
      end
      JOB_BYTE_LAST: begin
        if (step_q == 2'd0) begin
          res.mem_address = head_i.addr;
          res.mem_data    = head_i.data;
          fin             = 1'b0;
        end else begin
          res.result_kind  = KIND_CMD;
          res.command_byte = {3'd0, head_i.page, CMD_TX_LOW};
        end
      end
      default: begin
        res.result_kind = KIND_REJECT;
      end
    endcase
    // A payload write never carries last.
    res.last = fin && (head_i.cls != JOB_BYTE);
  end

  // Load the output register when a job is waiting and the register is empty or being drained.
  assign load  = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && fin;

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (load) begin
      step_d      = fin ? 2'd0 : 2'(step_q + 2'd1);
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ src/arcnet_tx_page_formatter.sv @@
// ARCNET transmit page formatter. An accepted item is queued as a job whose result words
// are registered by the back end. Throughput: one item accepted per cycle while the
// 4-deep job queue has room; the back sequencer emits one word per cycle unless stalled
// (start 3 or 4 words, payload byte 1, last byte 2), which sets the sustained rate.
// Reset (rst_ni low, async): page 2, no packet open, queue and output empty, node id 0.
// Depends on atf_pkg, atf_front, atf_queue and atf_back.
module arcnet_tx_page_formatter import atf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // item channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o,
  // node address register write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  logic q_full, push, pop, head_valid;
  job_t job, head;

  // Register writes go straight into the node address register, always take them.
  assign cfg_ready_o = 1'b1;

  // Front: accept, track the open packet, classify into a job word.
  atf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (job)
  );

  // Queue: decouple acceptance from multi-word expansion.
  atf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (job),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Back: walk each job's words into the registered output.
  atf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

@@ src/atf_checker.sv @@
// Port-level checker for the ARCNET transmit page formatter, bound to the top level.
// Depends on atf_pkg and arcnet_tx_page_formatter_defines.svh.
`include "arcnet_tx_page_formatter_defines.svh"

module atf_checker import atf_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input out_t out_data_i
);

  `ATF_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_i, out_ready_i, out_data_i, "result word dropped or changed while stalled")
  `ATF_ASSERT(a_reject_clean, clk_i, rst_ni, (out_valid_i && out_data_i.result_kind == KIND_REJECT) |-> (out_data_i.last && out_data_i.mem_address == '0 && out_data_i.mem_data == '0 && out_data_i.command_byte == '0), "reject word not clean")
  // Transmit enable only for page 2 or 3.
  `ATF_ASSERT(a_cmd_page, clk_i, rst_ni, (out_valid_i && out_data_i.result_kind == KIND_CMD) |-> (out_data_i.last && (out_data_i.command_byte == 8'h13 || out_data_i.command_byte == 8'h1B)), "bad transmit enable word")
  `ATF_ASSERT(a_write_page, clk_i, rst_ni, (out_valid_i && out_data_i.result_kind == KIND_WRITE) |-> (out_data_i.command_byte == '0 && out_data_i.mem_address[10]), "write outside transmit pages")

endmodule

bind arcnet_tx_page_formatter atf_checker u_atf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
